>>> hdl/smf_pkg.sv
// Shared types, constants and helper functions for the serial master with queues.
package smf_pkg;

	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int DATA_BITS  = 8;
	localparam int BIT_W      = $clog2(DATA_BITS + 1);
	localparam int CFG_W      = 8;
	localparam int CFG_IDX_W  = 2;

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_STATUS = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_PRESCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd2;

	localparam logic [7:0] PRESCALE_RESET = 8'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] write_byte;
		logic       miso_bit;
	} in_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic       sclk_level;
		logic       mosi_level;
		logic       busy_flag;
	} out_t;

	// What the control stage hands to the response stage for one item.
	typedef struct packed {
		logic       pop;        // data read that found the receive queue non-empty
		logic       load;       // frame start: shift register takes the transmit head
		logic       shift;      // falling edge: shift register moves left
		logic [7:0] status;     // status word, zero for other opcodes
		logic       sclk;
		logic       active;
		logic       busy;
	} stage_t;

	// Advance a queue pointer with wrap.
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	// Slot at head plus count, with wrap.
	function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
		input logic [CNT_W-1:0] n);
		logic [CNT_W:0] s;
		s = {{(CNT_W + 1 - PTR_W){1'b0}}, p} + {1'b0, n};
		if (s >= (CNT_W + 1)'(FIFO_DEPTH)) begin
			s = s - (CNT_W + 1)'(FIFO_DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

endpackage

>>> hdl/smf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module smf_ram #(
	parameter int DEPTH  = 8,
	parameter int DATA_W = 8,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/smf_engine.sv
// Control stage: configuration registers, queue pointers, serial timing and queue RAMs.
module smf_engine import smf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  in_t                  item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output stage_t               info,
	output logic [7:0]           tx_rdata,
	output logic [7:0]           rx_rdata
);

	logic [7:0]       prescale_q;
	logic [7:0]       rate_q;
	logic             enable_q;

	logic [CNT_W-1:0] tx_count_q, rx_count_q;
	logic [PTR_W-1:0] tx_head_q, rx_head_q;
	logic [7:0]       shift_in_q;
	logic [BIT_W-1:0] bit_index_q;
	logic [15:0]      period_q;
	logic             phase_q;
	logic             active_q;

	logic [CNT_W-1:0] tx_count_d, rx_count_d;
	logic [PTR_W-1:0] tx_head_d, rx_head_d;
	logic [7:0]       shift_in_d;
	logic [BIT_W-1:0] bit_index_d;
	logic [15:0]      period_d;
	logic             phase_d;
	logic             active_d;

	logic             tx_we, tx_re, rx_we, rx_re;
	logic [6:0]       pre_half;
	logic [15:0]      half;
	logic [15:0]      period_inc;
	logic [BIT_W-1:0] bit_inc;
	stage_t           info_d;

	// Half bit period in ticks; a prescale below two acts as two.
	always_comb begin
		pre_half = (prescale_q[7:1] == 7'd0) ? 7'd1 : prescale_q[7:1];
		half     = 16'({9'd0, pre_half} * ({8'd0, rate_q} + 16'd1));
	end

	always_comb begin
		tx_count_d  = tx_count_q;
		rx_count_d  = rx_count_q;
		tx_head_d   = tx_head_q;
		rx_head_d   = rx_head_q;
		shift_in_d  = shift_in_q;
		bit_index_d = bit_index_q;
		period_d    = period_q;
		phase_d     = phase_q;
		active_d    = active_q;
		tx_we       = 1'b0;
		tx_re       = 1'b0;
		rx_we       = 1'b0;
		rx_re       = 1'b0;
		info_d      = '0;
		period_inc  = period_q + 16'd1;
		bit_inc     = bit_index_q + BIT_W'(1);

		unique case (item.opcode)
			OP_TICK: begin
				if (enable_q) begin
					if (!active_q) begin
						if (tx_count_q != '0) begin
							tx_re       = 1'b1;
							info_d.load = 1'b1;
							tx_head_d   = ptr_inc(tx_head_q);
							tx_count_d  = tx_count_q - CNT_W'(1);
							shift_in_d  = '0;
							bit_index_d = '0;
							period_d    = '0;
							phase_d     = 1'b0;
							active_d    = 1'b1;
						end
					end else if (period_inc < half) begin
						period_d = period_inc;
					end else begin
						period_d = '0;
						if (!phase_q) begin
							phase_d    = 1'b1;
							shift_in_d = {shift_in_q[6:0], item.miso_bit};
						end else begin
							phase_d      = 1'b0;
							info_d.shift = 1'b1;
							bit_index_d  = bit_inc;
							if (bit_inc >= BIT_W'(DATA_BITS)) begin
								// Frame done: keep the byte only if the receive queue has room.
								if (rx_count_q < CNT_W'(FIFO_DEPTH)) begin
									rx_we      = 1'b1;
									rx_count_d = rx_count_q + CNT_W'(1);
								end
								active_d    = 1'b0;
								bit_index_d = '0;
								shift_in_d  = '0;
							end
						end
					end
				end
			end
			OP_WRITE: begin
				if (tx_count_q < CNT_W'(FIFO_DEPTH)) begin
					tx_we      = 1'b1;
					tx_count_d = tx_count_q + CNT_W'(1);
				end
			end
			OP_READ: begin
				if (rx_count_q != '0) begin
					rx_re      = 1'b1;
					info_d.pop = 1'b1;
					rx_head_d  = ptr_inc(rx_head_q);
					rx_count_d = rx_count_q - CNT_W'(1);
				end
			end
			OP_STATUS: begin
				info_d.status = {3'd0,
					active_q || (tx_count_q != '0),
					rx_count_q >= CNT_W'(FIFO_DEPTH),
					rx_count_q != '0,
					tx_count_q < CNT_W'(FIFO_DEPTH),
					tx_count_q == '0};
			end
			default: ;
		endcase

		info_d.sclk   = phase_d;
		info_d.active = active_d;
		info_d.busy   = active_d || (tx_count_d != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q  <= PRESCALE_RESET;
			rate_q      <= '0;
			enable_q    <= 1'b0;
			tx_count_q  <= '0;
			rx_count_q  <= '0;
			tx_head_q   <= '0;
			rx_head_q   <= '0;
			shift_in_q  <= '0;
			bit_index_q <= '0;
			period_q    <= '0;
			phase_q     <= 1'b0;
			active_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PRESCALE: prescale_q <= cfg_wdata;
				REG_RATE:     rate_q     <= cfg_wdata;
				REG_ENABLE: begin
					enable_q <= cfg_wdata[0];
					// Disabling aborts a frame in flight; the queues are kept.
					if (!cfg_wdata[0]) begin
						active_q    <= 1'b0;
						phase_q     <= 1'b0;
						period_q    <= '0;
						bit_index_q <= '0;
						shift_in_q  <= '0;
					end
				end
				default: ;
			endcase
		end else if (accept) begin
			tx_count_q  <= tx_count_d;
			rx_count_q  <= rx_count_d;
			tx_head_q   <= tx_head_d;
			rx_head_q   <= rx_head_d;
			shift_in_q  <= shift_in_d;
			bit_index_q <= bit_index_d;
			period_q    <= period_d;
			phase_q     <= phase_d;
			active_q    <= active_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info <= info_d;
		end
	end

	// Pushes and pops come from different items, so one queue is never read and
	// written at the same slot in one cycle; a write is visible to the next read.
	smf_ram #(.DEPTH(FIFO_DEPTH), .DATA_W(8)) u_tx_ram (
		.clk   (clk),
		.we    (accept && tx_we),
		.waddr (ptr_add(tx_head_q, tx_count_q)),
		.wdata (item.write_byte),
		.re    (accept && tx_re),
		.raddr (tx_head_q),
		.rdata (tx_rdata)
	);

	smf_ram #(.DEPTH(FIFO_DEPTH), .DATA_W(8)) u_rx_ram (
		.clk   (clk),
		.we    (accept && rx_we),
		.waddr (ptr_add(rx_head_q, rx_count_q)),
		.wdata (shift_in_q),
		.re    (accept && rx_re),
		.raddr (rx_head_q),
		.rdata (rx_rdata)
	);

endmodule

>>> hdl/smf_resp.sv
// Response stage: transmit shift register, result assembly and output register.
module smf_resp import smf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  stage_t     info,
	input  logic [7:0] tx_rdata,
	input  logic [7:0] rx_rdata,
	output logic       hold,
	output logic       out_valid,
	input  logic       out_stall,
	output out_t       out_data
);

	logic       valid_s2;
	logic       advance;
	logic [7:0] shift_out_q;
	logic [7:0] shift_out_d;
	out_t       result;

	assign advance = valid_s2 && (!out_valid || !out_stall);
	assign hold    = valid_s2 && !advance;

	always_comb begin
		shift_out_d = shift_out_q;
		if (info.load) begin
			shift_out_d = tx_rdata;
		end else if (info.shift) begin
			shift_out_d = {shift_out_q[6:0], 1'b0};
		end
		result.read_value = info.pop ? rx_rdata : info.status;
		result.sclk_level = info.sclk;
		result.mosi_level = info.active && shift_out_d[DATA_BITS-1];
		result.busy_flag  = info.busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid   <= 1'b0;
			shift_out_q <= '0;
		end else begin
			if (accept) begin
				valid_s2 <= 1'b1;
			end else if (advance) begin
				valid_s2 <= 1'b0;
			end
			if (advance) begin
				out_valid   <= 1'b1;
				shift_out_q <= shift_out_d;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data <= result;
		end
	end

endmodule

>>> hdl/spi_master_with_fifos_top.sv
// Top level of the mode 0 serial master with transmit and receive queues.
//
//   channel   direction  payload   transfer when
//   in        into       in_t      in_valid && !in_stall
//   out       out of     out_t     out_valid && !out_stall
//   cfg       into       8 bits    cfg_we
//
// One item per cycle while in_stall is low; each gives one registered result.
// Per item the control stage reads and updates the pointers and serial timing and
// issues at most one queue RAM access; the RAM's registered read feeds the result.
// Reset clears pointers, counts, timing and configuration; queue contents are not cleared.
// A stalled result holds the second stage, and in_stall rises only then.
module spi_master_with_fifos_top import smf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic       accept;
	stage_t     info;
	logic [7:0] tx_rdata;
	logic [7:0] rx_rdata;

	assign accept = in_valid && !in_stall;

	smf_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.info      (info),
		.tx_rdata  (tx_rdata),
		.rx_rdata  (rx_rdata)
	);

	smf_resp u_resp (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.info      (info),
		.tx_rdata  (tx_rdata),
		.rx_rdata  (rx_rdata),
		.hold      (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

>>> hdl/smf_checker.sv
// Port-level checks for the serial master, attached to the top level by bind.
module smf_checker import smf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	a_sclk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.sclk_level |-> out_data.busy_flag)
		else $error("serial clock high outside a frame");

	a_mosi_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.mosi_level |-> out_data.busy_flag)
		else $error("serial data driven outside a frame");

endmodule

bind spi_master_with_fifos_top smf_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

>>> verif/spi_master_with_fifos_top_tb.sv
// Self-checking testbench for the mode 0 serial master with transmit and receive queues.
module spi_master_with_fifos_top_tb;
	import smf_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam logic [7:0] ST_TFE = 8'h01;
	localparam logic [7:0] ST_TNF = 8'h02;
	localparam logic [7:0] ST_RNE = 8'h04;
	localparam logic [7:0] ST_RFF = 8'h08;
	localparam logic [7:0] ST_BSY = 8'h10;

	localparam int SETTLE_CYCLES   = 4;
	localparam int DRAIN_CYCLES    = 10;
	localparam int PRESSURE_AT     = 350;
	localparam int PRESSURE_CYCLES = 120;
	localparam int RANDOM_PHASES   = 10;

	typedef struct packed {
		logic       is_reg;
		logic       pinned;
		logic [1:0] code;
		logic [7:0] val;
		logic       miso;
		out_t       want;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_t                  in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_t                 out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	spi_master_with_fifos_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Expected bus replies, oldest first.
	out_t replies_due[$];

	int  mismatches = 0;
	int  results_seen = 0;
	int  settings_used = 0;
	int  op_seen[4] = '{0, 0, 0, 0};
	bit  steady = 1'b0;
	bit  pressure_done = 1'b0;

	// Shadow of the master: configuration, queues and serial engine.
	logic [7:0]           prescale_q = PRESCALE_RESET;
	logic [7:0]           rate_q = '0;
	logic                 enable_q = 1'b0;
	logic [7:0]           txq[FIFO_DEPTH];
	logic [7:0]           rxq[FIFO_DEPTH];
	int                   tx_fill = 0;
	int                   rx_fill = 0;
	int                   tx_rd = 0;
	int                   rx_rd = 0;
	logic [DATA_BITS-1:0] out_shreg = '0;
	logic [DATA_BITS-1:0] in_shreg = '0;
	int                   bits_sent = 0;
	int                   half_count = 0;
	logic                 sclk_q = 1'b0;
	logic                 in_frame = 1'b0;
	int                   frames_done = 0;
	int                   rx_lost = 0;
	int                   tx_lost = 0;

	function automatic int half_ticks();
		int p;
		p = int'(prescale_q & 8'hFE);
		if (p < 2) begin
			p = 2;
		end
		return (p >> 1) * (1 + int'(rate_q));
	endfunction

	function automatic void drop_frame();
		in_frame = 1'b0;
		sclk_q = 1'b0;
		half_count = 0;
		bits_sent = 0;
		out_shreg = '0;
		in_shreg = '0;
	endfunction

	function automatic void serial_tick(logic miso);
		if (!enable_q) begin
			return;
		end
		if (!in_frame) begin
			if (tx_fill != 0) begin
				out_shreg = txq[tx_rd];
				tx_rd = (tx_rd + 1) % FIFO_DEPTH;
				tx_fill--;
				in_shreg = '0;
				bits_sent = 0;
				half_count = 0;
				sclk_q = 1'b0;
				in_frame = 1'b1;
			end
			return;
		end
		half_count = (half_count + 1) & 16'hFFFF;
		if (half_count < half_ticks()) begin
			return;
		end
		half_count = 0;
		if (!sclk_q) begin
			// Rising edge samples the input line.
			sclk_q = 1'b1;
			in_shreg = {in_shreg[DATA_BITS-2:0], miso};
			return;
		end
		sclk_q = 1'b0;
		out_shreg = out_shreg << 1;
		bits_sent++;
		if (bits_sent >= DATA_BITS) begin
			if (rx_fill < FIFO_DEPTH) begin
				rxq[(rx_rd + rx_fill) % FIFO_DEPTH] = in_shreg;
				rx_fill++;
			end else begin
				rx_lost++;
			end
			frames_done++;
			drop_frame();
		end
	endfunction

	function automatic out_t master_step(in_t it);
		out_t r;
		r = '0;
		case (it.opcode)
			OP_TICK: serial_tick(it.miso_bit);
			OP_WRITE: begin
				if (tx_fill < FIFO_DEPTH) begin
					txq[(tx_rd + tx_fill) % FIFO_DEPTH] = it.write_byte;
					tx_fill++;
				end else begin
					tx_lost++;
				end
			end
			OP_READ: begin
				if (rx_fill != 0) begin
					r.read_value = rxq[rx_rd];
					rx_rd = (rx_rd + 1) % FIFO_DEPTH;
					rx_fill--;
				end
			end
			OP_STATUS: begin
				r.read_value = (tx_fill == 0 ? ST_TFE : 8'h00)
					| (tx_fill < FIFO_DEPTH ? ST_TNF : 8'h00)
					| (rx_fill != 0 ? ST_RNE : 8'h00)
					| (rx_fill >= FIFO_DEPTH ? ST_RFF : 8'h00)
					| ((in_frame || tx_fill != 0) ? ST_BSY : 8'h00);
			end
			default: ;
		endcase
		r.sclk_level = sclk_q;
		r.mosi_level = in_frame ? out_shreg[DATA_BITS-1] : 1'b0;
		r.busy_flag = in_frame || (tx_fill != 0);
		return r;
	endfunction

	function automatic void master_write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
		case (idx)
			REG_PRESCALE: prescale_q = v;
			REG_RATE: rate_q = v;
			REG_ENABLE: begin
				enable_q = v[0];
				// Disabling aborts a frame in flight; the queues keep their bytes.
				if (!v[0]) begin
					drop_frame();
				end
			end
			default: ;
		endcase
	endfunction

	// Mostly back-to-back, sometimes a short pause, rarely a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 40);
	endfunction

	function automatic row_t step_row(logic [1:0] op, logic [7:0] b, logic m);
		row_t r;
		r = '0;
		r.code = op;
		r.val = b;
		r.miso = m;
		return r;
	endfunction

	function automatic row_t pinned_row(logic [1:0] op, logic [7:0] b, logic m,
		logic [7:0] rv, logic sclk, logic mosi, logic busy);
		row_t r;
		r = step_row(op, b, m);
		r.pinned = 1'b1;
		r.want.read_value = rv;
		r.want.sclk_level = sclk;
		r.want.mosi_level = mosi;
		r.want.busy_flag = busy;
		return r;
	endfunction

	function automatic row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
		row_t r;
		r = '0;
		r.is_reg = 1'b1;
		r.code = idx;
		r.val = v;
		return r;
	endfunction

	task automatic offer(in_t it, logic pinned, out_t pinned_out);
		out_t p;
		int gap;
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		p = master_step(it);
		replies_due.push_back(pinned ? pinned_out : p);
		op_seen[it.opcode]++;
		gap = steady ? 0 : idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Register writes happen only once every reply is back and the pipeline has drained.
	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
		in_valid <= 1'b0;
		while (replies_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		master_write_reg(idx, v);
		cfg_we <= 1'b0;
	endtask

	// Receiving side: checks each transfer and stalls at random.
	initial begin
		out_t want;
		int   stall_left;
		int   gap;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					$error("unexpected result transfer: %h", out_data);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					results_seen++;
					if (out_data.read_value !== want.read_value) begin
						$error("read_value: expected %h, got %h", want.read_value,
							out_data.read_value);
						mismatches++;
					end
					if (out_data.sclk_level !== want.sclk_level) begin
						$error("sclk_level: expected %b, got %b", want.sclk_level,
							out_data.sclk_level);
						mismatches++;
					end
					if (out_data.mosi_level !== want.mosi_level) begin
						$error("mosi_level: expected %b, got %b", want.mosi_level,
							out_data.mosi_level);
						mismatches++;
					end
					if (out_data.busy_flag !== want.busy_flag) begin
						$error("busy_flag: expected %b, got %b", want.busy_flag,
							out_data.busy_flag);
						mismatches++;
					end
				end
			end
			// One long hold-off so the pipeline backs up into the input side.
			if (!pressure_done && results_seen >= PRESSURE_AT) begin
				pressure_done = 1'b1;
				stall_left = PRESSURE_CYCLES;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (steady) begin
				out_stall <= 1'b0;
			end else begin
				gap = idle_len();
				out_stall <= (gap != 0);
				stall_left = (gap > 0) ? gap - 1 : 0;
			end
		end
	end

	initial begin
		row_t       script[$];
		row_t       row;
		in_t        it;
		int         n_items;
		int         w_write;
		int         w_read;
		int         pick;
		logic [7:0] presc;
		logic [7:0] rate;
		logic       en;

		script = '{
			pinned_row(OP_STATUS, 8'h00, 1'b0, ST_TFE | ST_TNF, 1'b0, 1'b0, 1'b0),
			pinned_row(OP_READ,   8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0),
			pinned_row(OP_TICK,   8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0),
			pinned_row(OP_WRITE,  8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1),
			pinned_row(OP_WRITE,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1),
			pinned_row(OP_WRITE,  8'h80, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1),
			pinned_row(OP_WRITE,  8'h01, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1),
			pinned_row(OP_WRITE,  8'h55, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1),
			pinned_row(OP_WRITE,  8'hAA, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1),
			pinned_row(OP_WRITE,  8'h7F, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1),
			pinned_row(OP_WRITE,  8'hFE, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1),
			// The transmit queue is full, so this byte is refused.
			pinned_row(OP_WRITE,  8'h12, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1),
			pinned_row(OP_STATUS, 8'h00, 1'b0, ST_BSY, 1'b0, 1'b0, 1'b1),
			// A prescale of zero behaves as two: one tick per half period.
			reg_row(REG_PRESCALE, 8'h00),
			reg_row(REG_ENABLE, 8'h01),
			pinned_row(OP_TICK,   8'h00, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1),
			pinned_row(OP_TICK,   8'h00, 1'b1, 8'h00, 1'b1, 1'b1, 1'b1),
			pinned_row(OP_WRITE,  8'h33, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1),
			pinned_row(OP_STATUS, 8'h00, 1'b0, ST_BSY, 1'b1, 1'b1, 1'b1),
			pinned_row(OP_TICK,   8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1),
			step_row(OP_TICK, 8'h00, 1'b1),
			step_row(OP_TICK, 8'h00, 1'b0),
			// Disabling mid-frame drops the frame but keeps the queued bytes.
			reg_row(REG_ENABLE, 8'h00),
			pinned_row(OP_STATUS, 8'h00, 1'b0, ST_BSY, 1'b0, 1'b0, 1'b1),
			pinned_row(OP_TICK,   8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1),
			reg_row(REG_UNUSED, 8'hFF),
			reg_row(REG_RATE, 8'hFF),
			reg_row(REG_PRESCALE, 8'hFF),
			reg_row(REG_ENABLE, 8'h01),
			step_row(OP_TICK, 8'h00, 1'b1),
			step_row(OP_TICK, 8'h00, 1'b0)
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			row = script[i];
			if (row.is_reg) begin
				set_reg(row.code, row.val);
				settings_used++;
			end else begin
				it.opcode = row.code;
				it.write_byte = row.val;
				it.miso_bit = row.miso;
				offer(it, row.pinned, row.want);
			end
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin presc = 8'd2;   rate = 8'd0;   n_items = 100; end
				1: begin presc = 8'd1;   rate = 8'd1;   n_items = 80;  end
				2: begin presc = 8'd254; rate = 8'd0;   n_items = 200; end
				3: begin presc = 8'd2;   rate = 8'd255; n_items = 40;  end
				4: begin presc = 8'd255; rate = 8'd255; n_items = 30;  end
				default: begin
					presc = 8'($urandom_range(0, 9));
					rate = 8'($urandom_range(0, 2));
					n_items = $urandom_range(50, 70);
				end
			endcase
			en = (ph < 5) ? 1'b1 : ($urandom_range(0, 9) != 0);
			set_reg(REG_PRESCALE, presc);
			set_reg(REG_RATE, rate);
			set_reg(REG_ENABLE, {7'd0, en});
			settings_used++;
			steady = (ph % 4 == 3);
			w_write = 12;
			w_read = (ph % 3 == 0) ? 2 : ((ph % 3 == 1) ? 10 : 25);
			for (int k = 0; k < n_items; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < w_write) begin
					it.opcode = OP_WRITE;
				end else if (pick < w_write + w_read) begin
					it.opcode = OP_READ;
				end else if (pick < w_write + w_read + 8) begin
					it.opcode = OP_STATUS;
				end else begin
					it.opcode = OP_TICK;
				end
				it.write_byte = 8'($urandom_range(0, 255));
				it.miso_bit = 1'($urandom_range(0, 1));
				offer(it, 1'b0, '0);
			end
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		while (replies_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d transfers (%0d tick, %0d write, %0d read, %0d status), %0d settings.",
			op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3], op_seen[OP_TICK],
			op_seen[OP_WRITE], op_seen[OP_READ], op_seen[OP_STATUS], settings_used);
		$display("%0d results checked, %0d frames, %0d rx bytes dropped, %0d writes refused.",
			results_seen, frames_done, rx_lost, tx_lost);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
